### rtl/xmr_pkg.sv
// Package for the XMODEM packet receiver: codes, phase and event types.
// No dependencies; every other file refers to it by scoped names.
package xmr_pkg;

  localparam int unsigned PayloadBytes = 128;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  localparam logic [7:0] RetryLimitReset = 8'd10;

  localparam logic [7:0] CODE_ACK = 8'h06;
  localparam logic [7:0] CODE_NAK = 8'h15;
  localparam logic [7:0] CODE_CAN = 8'h18;
  localparam logic [7:0] CODE_EOT = 8'h04;

  localparam logic [1:0] PE_NONE    = 2'd0;
  localparam logic [1:0] PE_COMMIT  = 2'd1;
  localparam logic [1:0] PE_DISCARD = 2'd2;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_BYTE    = 2'd1,
    ACT_TIMEOUT = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_SEQ     = 3'd2,
    PH_INV     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5,
    PH_DONE    = 3'd6,
    PH_FAILED  = 3'd7
  } phase_e;

  // What the front hands to the back for one accepted item
  typedef enum logic [2:0] {
    EV_NAK     = 3'd0,  // start: NAK
    EV_FINISH  = 3'd1,  // EOT acknowledged
    EV_DATA    = 3'd2,  // tentative payload byte
    EV_COMMIT  = 3'd3,  // good packet: ACK
    EV_DISCARD = 3'd4,  // bad packet: NAK
    EV_CANCEL  = 3'd5   // retries exhausted: CAN twice
  } event_e;

  typedef struct packed {
    event_e      kind;
    logic [7:0]  data;
    logic [23:0] offset;
  } event_t;

endpackage

### rtl/xmr_front.sv
// Front end: accepts input transactions, keeps the protocol state and
// classifies each item into at most one event for the back end. Uses xmr_pkg.
module xmr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [1:0]         action_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i,
  output logic               ev_push_o,
  output xmr_pkg::event_t    ev_o
);

  xmr_pkg::phase_e phase_q, phase_d;
  logic [7:0]  retry_limit_q, retry_limit_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  inv_q, inv_d;
  logic [7:0]  retries_q, retries_d;
  logic [23:0] base_q, base_d;
  logic        mid;
  logic [8:0]  idx_inc;
  logic        good;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= xmr_pkg::PH_IDLE;
      retry_limit_q <= xmr_pkg::RetryLimitReset;
      count_q       <= '0;
      sum_q         <= '0;
      idx_q         <= '0;
      seq_q         <= '0;
      inv_q         <= '0;
      retries_q     <= xmr_pkg::RetryLimitReset;
      base_q        <= '0;
    end else begin
      phase_q       <= phase_d;
      retry_limit_q <= retry_limit_d;
      count_q       <= count_d;
      sum_q         <= sum_d;
      idx_q         <= idx_d;
      seq_q         <= seq_d;
      inv_q         <= inv_d;
      retries_q     <= retries_d;
      base_q        <= base_d;
    end
  end

  assign mid = (phase_q == xmr_pkg::PH_SEQ) || (phase_q == xmr_pkg::PH_INV) ||
               (phase_q == xmr_pkg::PH_PAYLOAD) || (phase_q == xmr_pkg::PH_CHECK);
  assign idx_inc = {1'b0, idx_q} + 9'd1;
  assign good = (rx_byte_i == sum_q) && (seq_q == ~inv_q) &&
                (seq_q == count_q + 8'd1);

  always_comb begin
    phase_d       = phase_q;
    retry_limit_d = cfg_we_i ? cfg_data_i : retry_limit_q;
    count_d       = count_q;
    sum_d         = sum_q;
    idx_d         = idx_q;
    seq_d         = seq_q;
    inv_d         = inv_q;
    retries_d     = retries_q;
    base_d        = base_q;
    ev_push_o     = 1'b0;
    ev_o          = '{kind: xmr_pkg::EV_NAK, data: 8'd0, offset: 24'd0};

    if (accept_i) begin
      case (xmr_pkg::action_e'(action_i))
        xmr_pkg::ACT_START: begin
          count_d   = '0;
          base_d    = '0;
          sum_d     = '0;
          idx_d     = '0;
          seq_d     = '0;
          inv_d     = '0;
          retries_d = retry_limit_q;
          phase_d   = xmr_pkg::PH_HEADER;
          ev_push_o = 1'b1;
        end
        xmr_pkg::ACT_TIMEOUT: begin
          if (mid) begin
            ev_push_o = 1'b1;
            if (retries_q <= 8'd1) begin
              retries_d = '0;
              phase_d   = xmr_pkg::PH_FAILED;
              ev_o.kind = xmr_pkg::EV_CANCEL;
            end else begin
              retries_d = retries_q - 8'd1;
              phase_d   = xmr_pkg::PH_HEADER;
              ev_o.kind = xmr_pkg::EV_DISCARD;
            end
          end
        end
        xmr_pkg::ACT_BYTE: begin
          case (phase_q)
            xmr_pkg::PH_HEADER: begin
              if (rx_byte_i == xmr_pkg::CODE_EOT) begin
                phase_d   = xmr_pkg::PH_DONE;
                ev_push_o = 1'b1;
                ev_o.kind = xmr_pkg::EV_FINISH;
              end else begin
                sum_d   = '0;
                idx_d   = '0;
                phase_d = xmr_pkg::PH_SEQ;
              end
            end
            xmr_pkg::PH_SEQ: begin
              seq_d   = rx_byte_i;
              phase_d = xmr_pkg::PH_INV;
            end
            xmr_pkg::PH_INV: begin
              inv_d   = rx_byte_i;
              phase_d = xmr_pkg::PH_PAYLOAD;
            end
            xmr_pkg::PH_PAYLOAD: begin
              sum_d       = sum_q + rx_byte_i;
              idx_d       = idx_inc[7:0];
              ev_push_o   = 1'b1;
              ev_o.kind   = xmr_pkg::EV_DATA;
              ev_o.data   = rx_byte_i;
              ev_o.offset = base_q + {16'd0, idx_q};
              if (idx_inc >= 9'(xmr_pkg::PayloadBytes)) begin
                phase_d = xmr_pkg::PH_CHECK;
              end
            end
            xmr_pkg::PH_CHECK: begin
              ev_push_o = 1'b1;
              if (good) begin
                count_d   = count_q + 8'd1;
                base_d    = base_q + 24'(xmr_pkg::PayloadBytes);
                retries_d = retry_limit_q;
                phase_d   = xmr_pkg::PH_HEADER;
                ev_o.kind = xmr_pkg::EV_COMMIT;
              end else if (retries_q <= 8'd1) begin
                retries_d = '0;
                phase_d   = xmr_pkg::PH_FAILED;
                ev_o.kind = xmr_pkg::EV_CANCEL;
              end else begin
                retries_d = retries_q - 8'd1;
                phase_d   = xmr_pkg::PH_HEADER;
                ev_o.kind = xmr_pkg::EV_DISCARD;
              end
            end
            default: begin
              // idle, done, failed: byte ignored
            end
          endcase
        end
        default: begin
          // unused action code
        end
      endcase
    end
  end

endmodule

### rtl/xmr_back.sv
// Back end: event queue between front and result ports, and expansion of
// each event into one or two result transactions. Uses xmr_pkg.
module xmr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ev_push_i,
  input  xmr_pkg::event_t   ev_i,
  output logic              full_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic              tx_valid_o,
  output logic [7:0]        tx_byte_o,
  output logic              data_valid_o,
  output logic [7:0]        data_byte_o,
  output logic [23:0]       data_offset_o,
  output logic [1:0]        packet_end_o,
  output logic              finished_o,
  output logic              failed_o,
  output logic              last_o
);

  xmr_pkg::event_t mem_q [xmr_pkg::QueueDepth];
  logic [xmr_pkg::QueuePtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [xmr_pkg::QueueCntW-1:0] cnt_q, cnt_d;
  logic            second_q, second_d;
  logic            do_pop, deq;
  xmr_pkg::event_t head;

  assign full_o  = (cnt_q == xmr_pkg::QueueCntW'(xmr_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head    = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;
  // a cancel event stays at the head until both CAN results have gone
  assign deq     = do_pop && !((head.kind == xmr_pkg::EV_CANCEL) && !second_q);

  always_ff @(posedge clk_i) begin
    if (ev_push_i) begin
      mem_q[wr_q] <= ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q     <= '0;
      rd_q     <= '0;
      cnt_q    <= '0;
      second_q <= 1'b0;
    end else begin
      wr_q     <= wr_d;
      rd_q     <= rd_d;
      cnt_q    <= cnt_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    wr_d     = ev_push_i ? wr_q + 1'b1 : wr_q;
    rd_d     = deq ? rd_q + 1'b1 : rd_q;
    cnt_d    = cnt_q;
    second_d = second_q;
    if (ev_push_i && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!ev_push_i && deq) begin
      cnt_d = cnt_q - 1'b1;
    end
    if (do_pop) begin
      second_d = !deq;
    end
  end

  always_comb begin
    tx_valid_o    = 1'b0;
    tx_byte_o     = 8'd0;
    data_valid_o  = 1'b0;
    data_byte_o   = 8'd0;
    data_offset_o = 24'd0;
    packet_end_o  = xmr_pkg::PE_NONE;
    finished_o    = 1'b0;
    failed_o      = 1'b0;
    last_o        = 1'b1;
    case (head.kind)
      xmr_pkg::EV_NAK: begin
        tx_valid_o = 1'b1;
        tx_byte_o  = xmr_pkg::CODE_NAK;
      end
      xmr_pkg::EV_FINISH: begin
        tx_valid_o = 1'b1;
        tx_byte_o  = xmr_pkg::CODE_ACK;
        finished_o = 1'b1;
      end
      xmr_pkg::EV_DATA: begin
        data_valid_o  = 1'b1;
        data_byte_o   = head.data;
        data_offset_o = head.offset;
      end
      xmr_pkg::EV_COMMIT: begin
        tx_valid_o   = 1'b1;
        tx_byte_o    = xmr_pkg::CODE_ACK;
        packet_end_o = xmr_pkg::PE_COMMIT;
      end
      xmr_pkg::EV_DISCARD: begin
        tx_valid_o   = 1'b1;
        tx_byte_o    = xmr_pkg::CODE_NAK;
        packet_end_o = xmr_pkg::PE_DISCARD;
      end
      xmr_pkg::EV_CANCEL: begin
        tx_valid_o = 1'b1;
        tx_byte_o  = xmr_pkg::CODE_CAN;
        if (second_q) begin
          failed_o = 1'b1;
        end else begin
          packet_end_o = xmr_pkg::PE_DISCARD;
          last_o       = 1'b0;
        end
      end
      default: begin
        tx_valid_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/xmodem_packet_receiver.sv
// Top level of the XMODEM packet receiver: front end, event queue / result
// back end and assertions. Depends on xmr_pkg, xmr_front and xmr_back.
//
// Usage:
//  - Input queue side: drive action_i / rx_byte_i and raise push; the
//    transaction is taken on a clock edge with push high and full low.
//    action 0 starts a transfer, 1 delivers a received byte, 2 a timeout.
//  - Result queue side: while empty is low the oldest result is on the
//    result ports; it is taken on an edge with pop high and empty low.
//    last_o marks the final result of one input transaction.
//  - Config: cfg_valid_i / cfg_ready_o / cfg_data_i write retry_limit.
//    cfg_ready_o is always high; write only while the block is idle.
// Timing: one input transaction per cycle while full is low. Its result (if any)
// is visible on the result ports the cycle after acceptance when the
// queue was empty. A cancel gives two results and takes two pops.
// A four-entry event queue between front and back sets how far the
// receiver may stall; full rises once four events are waiting.
// Reset: phase idle, retry limit 10, queue empty, no results pending.
module xmodem_packet_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic [23:0] data_offset_o,
  output logic [1:0]  packet_end_o,
  output logic        finished_o,
  output logic        failed_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic            accept;
  logic            ev_push;
  xmr_pkg::event_t ev;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  xmr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .action_i   (action_i),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .ev_push_o  (ev_push),
    .ev_o       (ev)
  );

  xmr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_push_i     (ev_push),
    .ev_i          (ev),
    .full_o        (full),
    .empty_o       (empty),
    .pop_i         (pop),
    .tx_valid_o    (tx_valid_o),
    .tx_byte_o     (tx_byte_o),
    .data_valid_o  (data_valid_o),
    .data_byte_o   (data_byte_o),
    .data_offset_o (data_offset_o),
    .packet_end_o  (packet_end_o),
    .finished_o    (finished_o),
    .failed_o      (failed_o),
    .last_o        (last_o)
  );

`ifndef NO_ASSERTIONS
  // a start always yields a result, so the queue cannot be empty after it
  a_start_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == xmr_pkg::ACT_START) |=> !empty)
    else $error("start transaction left no result");

  // start into an empty queue shows NAK at the head next cycle
  a_start_nak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == xmr_pkg::ACT_START && empty) |=>
    (tx_valid_o && tx_byte_o == xmr_pkg::CODE_NAK && last_o))
    else $error("start did not reply NAK");

  // first CAN of a cancel is followed by the failure result
  a_cancel_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && tx_byte_o == xmr_pkg::CODE_CAN && !last_o) |=>
    (!empty && failed_o && last_o && tx_byte_o == xmr_pkg::CODE_CAN))
    else $error("cancel not followed by failure result");
`endif

endmodule

### verif/xmodem_packet_receiver_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for xmodem_packet_receiver: directed XMODEM traffic with
// random payloads against a cycle-free behavioural predictor. Depends on xmr_pkg and the RTL.
module xmodem_packet_receiver_tb;

  // Action code 3 has no meaning and must be ignored by the block
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Cycles allowed for items with no result to pass through the block
  localparam int DRAIN_CYCLES = 16;
  localparam int HDR_POSITIONS = xmr_pkg::PayloadBytes + 3;  // seq, inv, payload, checksum

  // One result transaction as seen on the result ports
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [23:0] data_offset;
    logic [1:0]  packet_end;
    logic        finished;
    logic        failed;
    logic        last;
  } rx_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  action_i = xmr_pkg::ACT_START;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        tx_valid_o;
  logic [7:0]  tx_byte_o;
  logic        data_valid_o;
  logic [7:0]  data_byte_o;
  logic [23:0] data_offset_o;
  logic [1:0]  packet_end_o;
  logic        finished_o;
  logic        failed_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = 8'h00;

  xmodem_packet_receiver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .rx_byte_i     (rx_byte_i),
    .empty         (empty),
    .pop           (pop),
    .tx_valid_o    (tx_valid_o),
    .tx_byte_o     (tx_byte_o),
    .data_valid_o  (data_valid_o),
    .data_byte_o   (data_byte_o),
    .data_offset_o (data_offset_o),
    .packet_end_o  (packet_end_o),
    .finished_o    (finished_o),
    .failed_o      (failed_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run-time idle ratios, in percent, for each side of the block
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Statistics and error tally
  int n_errors = 0;
  int n_live_items = 0;   // transactions the block did not simply ignore
  int n_checked = 0;
  int n_commits = 0;
  int n_discards = 0;
  int n_cancels = 0;
  int n_finishes = 0;

  // ---------------------------------------------------------------------
  // Receiver predictor: its own copy of the protocol state and register
  // ---------------------------------------------------------------------
  rx_result_t       pending_results[$];
  logic [7:0]       retry_limit_q;
  xmr_pkg::phase_e  rx_phase;
  logic [7:0]       pkt_count;
  logic [7:0]       sum_acc;
  logic [7:0]       pay_idx;
  logic [7:0]       seq_q;
  logic [7:0]       inv_seq_q;
  logic [7:0]       retries;
  logic [23:0]      image_base;

  task automatic reset_receiver_model();
    retry_limit_q = xmr_pkg::RetryLimitReset;
    rx_phase      = xmr_pkg::PH_IDLE;
    pkt_count     = '0;
    sum_acc       = '0;
    pay_idx       = '0;
    seq_q         = '0;
    inv_seq_q     = '0;
    retries       = xmr_pkg::RetryLimitReset;
    image_base    = '0;
  endtask

  // Bad packet or mid-packet timeout: NAK, or CAN twice once retries run out
  task automatic drop_packet();
    rx_result_t r;
    r = '0;
    r.tx_valid   = 1'b1;
    r.packet_end = xmr_pkg::PE_DISCARD;
    rx_phase     = xmr_pkg::PH_HEADER;
    if (retries <= 8'd1) begin
      retries   = '0;
      rx_phase  = xmr_pkg::PH_FAILED;
      r.tx_byte = xmr_pkg::CODE_CAN;
      pending_results.push_back(r);
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte  = xmr_pkg::CODE_CAN;
      r.failed   = 1'b1;
      r.last     = 1'b1;
      pending_results.push_back(r);
      n_cancels++;
    end else begin
      retries   = retries - 8'd1;
      r.tx_byte = xmr_pkg::CODE_NAK;
      r.last    = 1'b1;
      pending_results.push_back(r);
      n_discards++;
    end
  endtask

  task automatic predict_receiver(input logic [1:0] act, input logic [7:0] b);
    rx_result_t r;
    logic       mid;
    r   = '0;
    mid = rx_phase inside {xmr_pkg::PH_SEQ, xmr_pkg::PH_INV, xmr_pkg::PH_PAYLOAD,
                           xmr_pkg::PH_CHECK};
    if (act == xmr_pkg::ACT_START) begin
      pkt_count  = '0;
      image_base = '0;
      sum_acc    = '0;
      pay_idx    = '0;
      seq_q      = '0;
      inv_seq_q  = '0;
      retries    = retry_limit_q;
      rx_phase   = xmr_pkg::PH_HEADER;
      r.tx_valid = 1'b1;
      r.tx_byte  = xmr_pkg::CODE_NAK;
      r.last     = 1'b1;
      pending_results.push_back(r);
      n_live_items++;
    end else if (act == xmr_pkg::ACT_TIMEOUT) begin
      // a timeout only matters once a header has been seen
      if (mid) begin
        drop_packet();
        n_live_items++;
      end
    end else if (act == xmr_pkg::ACT_BYTE) begin
      if (rx_phase != xmr_pkg::PH_IDLE && rx_phase != xmr_pkg::PH_DONE &&
          rx_phase != xmr_pkg::PH_FAILED)
        n_live_items++;
      case (rx_phase)
        xmr_pkg::PH_HEADER: begin
          if (b == xmr_pkg::CODE_EOT) begin
            rx_phase   = xmr_pkg::PH_DONE;
            r.tx_valid = 1'b1;
            r.tx_byte  = xmr_pkg::CODE_ACK;
            r.finished = 1'b1;
            r.last     = 1'b1;
            pending_results.push_back(r);
            n_finishes++;
          end else begin
            sum_acc  = '0;
            pay_idx  = '0;
            rx_phase = xmr_pkg::PH_SEQ;
          end
        end
        xmr_pkg::PH_SEQ: begin
          seq_q    = b;
          rx_phase = xmr_pkg::PH_INV;
        end
        xmr_pkg::PH_INV: begin
          inv_seq_q = b;
          rx_phase  = xmr_pkg::PH_PAYLOAD;
        end
        xmr_pkg::PH_PAYLOAD: begin
          // every payload byte goes straight out, tagged with its offset
          sum_acc       = sum_acc + b;
          r.data_valid  = 1'b1;
          r.data_byte   = b;
          r.data_offset = image_base + 24'(pay_idx);
          r.last        = 1'b1;
          pending_results.push_back(r);
          pay_idx = pay_idx + 8'd1;
          if (32'(pay_idx) >= xmr_pkg::PayloadBytes) rx_phase = xmr_pkg::PH_CHECK;
        end
        xmr_pkg::PH_CHECK: begin
          if (b == sum_acc && seq_q == ~inv_seq_q && seq_q == pkt_count + 8'd1) begin
            pkt_count    = pkt_count + 8'd1;
            image_base   = image_base + 24'(xmr_pkg::PayloadBytes);
            retries      = retry_limit_q;
            rx_phase     = xmr_pkg::PH_HEADER;
            r.tx_valid   = 1'b1;
            r.tx_byte    = xmr_pkg::CODE_ACK;
            r.packet_end = xmr_pkg::PE_COMMIT;
            r.last       = 1'b1;
            pending_results.push_back(r);
            n_commits++;
          end else begin
            drop_packet();
          end
        end
        default: ;  // idle, done and failed ignore bytes
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: random pop, each accepted transaction checked in order
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  task automatic check_result();
    rx_result_t want;
    if (pending_results.size() == 0) begin
      $error("result transaction with nothing expected (tx 0x%0h data 0x%0h)",
             tx_byte_o, data_byte_o);
      n_errors++;
    end else begin
      want = pending_results.pop_front();
      n_checked++;
      check_field("tx_valid",    want.tx_valid,    tx_valid_o);
      check_field("tx_byte",     want.tx_byte,     tx_byte_o);
      check_field("data_valid",  want.data_valid,  data_valid_o);
      check_field("data_byte",   want.data_byte,   data_byte_o);
      check_field("data_offset", want.data_offset, data_offset_o);
      check_field("packet_end",  want.packet_end,  packet_end_o);
      check_field("finished",    want.finished,    finished_o);
      check_field("failed",      want.failed,      failed_o);
      check_field("last",        want.last,        last_o);
    end
  endtask

  // Outputs are sampled just after the edge, before any flop has updated
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_result();
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Push one input transaction; push stays high afterwards so that
  // back-to-back transactions need no extra edge.
  task automatic send_item(input logic [1:0] act, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    action_i  <= act;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_receiver(act, b);
  endtask

  // Sender holds off until every expected result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_retry_limit(input logic [7:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i   <= 1'b0;
    retry_limit_q = value;
  endtask

  // One packet. cut picks the position (1 = sequence byte, last = checksum)
  // at which a timeout replaces the byte; 0 sends the whole packet.
  task automatic send_packet(input logic [7:0] seq, input logic [7:0] inv,
                             input logic sum_ok, input int cut);
    logic [7:0] hdr;
    logic [7:0] sum;
    logic [7:0] b;
    int         pos;
    hdr = 8'($urandom);
    if (hdr == xmr_pkg::CODE_EOT) hdr = 8'hFF;
    send_item(xmr_pkg::ACT_BYTE, hdr);
    sum = '0;
    for (pos = 1; pos <= HDR_POSITIONS; pos++) begin
      if (pos == cut) begin
        send_item(xmr_pkg::ACT_TIMEOUT, 8'($urandom));
        return;
      end
      if (pos == 1) begin
        b = seq;
      end else if (pos == 2) begin
        b = inv;
      end else if (pos < HDR_POSITIONS) begin
        // payload extremes turn up now and then
        case ($urandom_range(7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        sum = sum + b;
      end else begin
        b = sum_ok ? sum : sum ^ 8'($urandom_range(1, 255));
      end
      send_item(xmr_pkg::ACT_BYTE, b);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Idle swallows bytes, timeouts and code 3; header-wait timeouts and code 3; done bytes and timeouts
  task automatic test_ignored_events();
    send_item(xmr_pkg::ACT_BYTE, 8'h00);
    send_item(xmr_pkg::ACT_BYTE, 8'hFF);
    send_item(xmr_pkg::ACT_TIMEOUT, 8'h55);
    send_item(ACT_UNUSED, 8'hAA);
    send_item(xmr_pkg::ACT_START, 8'hFF);
    send_item(xmr_pkg::ACT_TIMEOUT, 8'h00);
    send_item(ACT_UNUSED, 8'h04);
    send_item(xmr_pkg::ACT_BYTE, xmr_pkg::CODE_EOT);
    send_item(xmr_pkg::ACT_BYTE, 8'h01);
    send_item(xmr_pkg::ACT_TIMEOUT, 8'hFF);
    send_item(xmr_pkg::ACT_START, 8'h00);
  endtask

  // Good packet, a repeat, retry reload on commit and early timeouts
  task automatic test_packet_checks();
    set_retry_limit(8'd2);
    send_item(xmr_pkg::ACT_START, 8'h00);
    send_packet(8'd1, ~8'd1, 1'b1, 1);                  // timeout for the sequence byte
    send_packet(8'd1, ~8'd1, 1'b1, 0);                  // good: retries reloaded
    send_packet(8'd1, ~8'd1, 1'b1, 0);                  // repeat: NAK, not cancel
    send_item(xmr_pkg::ACT_START, 8'h00);
    send_packet(8'd1, ~8'd1, 1'b1, 2);                  // timeout for the inverse
    // a start in the middle of a packet restarts the transfer
    send_item(xmr_pkg::ACT_BYTE, 8'h01);
    send_item(xmr_pkg::ACT_BYTE, 8'h01);
    send_item(ACT_UNUSED, 8'h15);
    send_item(xmr_pkg::ACT_START, 8'h00);
    send_item(xmr_pkg::ACT_BYTE, xmr_pkg::CODE_EOT);
  endtask

  // Cancel on the last retry, including the zero limit
  task automatic test_retry_exhaustion();
    set_retry_limit(8'd1);
    send_item(xmr_pkg::ACT_START, 8'h00);
    send_packet(8'd1, 8'd1, 1'b1, 0);                   // inverse wrong: cancels
    send_item(xmr_pkg::ACT_BYTE, 8'h01);
    send_item(xmr_pkg::ACT_TIMEOUT, 8'h00);
    set_retry_limit(8'd0);
    send_item(xmr_pkg::ACT_START, 8'h00);
    send_packet(8'd1, ~8'd1, 1'b1, HDR_POSITIONS);      // timeout for the checksum
    set_retry_limit(8'd3);
    send_item(xmr_pkg::ACT_START, 8'h00);
    send_packet(8'd1, ~8'd1, 1'b1, 1);
    send_packet(8'd1, ~8'd1, 1'b1, 3);
    send_packet(8'd1, ~8'd1, 1'b1, 1);                  // third bad one cancels
    send_item(xmr_pkg::ACT_START, 8'h00);
  endtask

  // No idling on either side: bad checksum, then EOT and a byte after done
  task automatic test_back_to_back();
    set_retry_limit(8'd255);
    send_item(xmr_pkg::ACT_START, 8'h00);
    send_packet(8'd1, ~8'd1, 1'b0, 0);                  // checksum wrong
    send_item(xmr_pkg::ACT_BYTE, xmr_pkg::CODE_EOT);
    send_item(xmr_pkg::ACT_BYTE, 8'h00);
  endtask

  initial begin
    reset_receiver_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 30;
    recv_idle_pct = 55;
    test_ignored_events();
    test_packet_checks();

    send_idle_pct = 55;
    recv_idle_pct = 30;
    test_retry_exhaustion();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_back_to_back();

    wait_drained();
    $display("Covered %0d live input transactions and %0d result transactions checked;",
             n_live_items, n_checked);
    $display("packets committed %0d, discarded %0d, transfers cancelled %0d, finished %0d",
             n_commits, n_discards, n_cancels, n_finishes);
    if (n_errors == 0) begin
      $display("xmodem_packet_receiver_tb: clean");
    end else begin
      $display("xmodem_packet_receiver_tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timed out with %0d result transactions outstanding", pending_results.size());
    $display("xmodem_packet_receiver_tb: errors");
    $finish;
  end

endmodule

### files.f
rtl/xmr_pkg.sv
rtl/xmr_front.sv
rtl/xmr_back.sv
rtl/xmodem_packet_receiver.sv
verif/xmodem_packet_receiver_tb.sv
